FILE: src/tga_rle_pixel_decoder_unit_assert.svh
// Assertion macros for the TGA run-length pixel decoder.
// Included by the top level; simulation builds get checks, synthesis gets nothing.
`ifndef TGA_RLE_PIXEL_DECODER_UNIT_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// check a property on every rising edge outside reset
`define TGA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tga_rle_pixel_decoder_unit: assertion failed");
// check that a condition never holds outside reset
`define TGA_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tga_rle_pixel_decoder_unit: forbidden condition seen");
`else
`define TGA_ASSERT(label, clk, rst_n, prop)
`define TGA_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

FILE: src/tgarle_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
// Used by the front queue, the back decoder and the top level.
`timescale 1ns / 1ps

package tgarle_pkg;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DIM_W   = 16;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned OUT_D_W = 72;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_PIXEL_DEPTH_32 = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_IMAGE_WIDTH    = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_IMAGE_HEIGHT   = 2'd2;

  // input kinds carried on tuser
  localparam logic ACT_DATA      = 1'b0;
  localparam logic ACT_NEW_IMAGE = 1'b1;

  // header decoding and pixel constants
  localparam logic [BYTE_W-1:0] RUN_BIAS     = 8'd127;
  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // classified item held in the queue
  typedef struct packed {
    logic              is_cmd;   // start a new image
    logic              is_run;   // header byte would open a run packet
    logic [BYTE_W-1:0] count;    // pixel count if this byte is a header
    logic [BYTE_W-1:0] data;     // raw byte
  } q_item_t;

  // queue status seen by the top level
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

FILE: src/tgarle_front.sv
// Front part of the TGA run-length decoder: accepts and classifies items and
// queues them for the back part. Depends on tgarle_pkg.
`timescale 1ns / 1ps

module tgarle_front #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tgarle_pkg::BYTE_W-1:0]   in_tdata,   // [7:0] data_byte
  input  logic                            in_tuser,   // [0] action
  input  logic                            pop,
  output tgarle_pkg::q_item_t             head,
  output logic                            head_valid,
  output tgarle_pkg::q_status_t           status
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  tgarle_pkg::q_item_t mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  tgarle_pkg::q_item_t cls;
  logic push;
  logic do_pop;

  // classify the incoming byte
  always_comb begin
    cls.is_cmd = (in_tuser == tgarle_pkg::ACT_NEW_IMAGE);
    cls.is_run = in_tdata[tgarle_pkg::BYTE_W-1];
    cls.count  = cls.is_run ? (in_tdata - tgarle_pkg::RUN_BIAS) : (in_tdata + 8'd1);
    cls.data   = in_tdata;
  end

  assign in_tready    = (cnt_r != FULL_CNT);
  assign push         = in_tvalid && in_tready;
  assign head_valid   = (cnt_r != '0);
  assign do_pop       = pop && head_valid;
  assign head         = mem_r[rd_ptr_r];
  assign status.empty = !head_valid;
  assign status.full  = !in_tready;

  // advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // store classified item
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

FILE: src/tgarle_back.sv
// Back part of the TGA run-length decoder: packet state, pixel assembly,
// run clipping and the output register. Depends on tgarle_pkg.
`timescale 1ns / 1ps

module tgarle_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                depth_32,
  input  logic [tgarle_pkg::POS_W-1:0]        total,
  input  tgarle_pkg::q_item_t                 head,
  input  logic                                head_valid,
  output logic                                pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tgarle_pkg::OUT_D_W-1:0]      out_tdata,
  output logic                                out_tlast
);

  typedef enum logic [2:0] {
    PH_HDR = 3'b001,
    PH_RUN = 3'b010,
    PH_RAW = 3'b100
  } phase_t;

  localparam int unsigned BW = tgarle_pkg::BYTE_W;
  localparam int unsigned PW = tgarle_pkg::POS_W;

  phase_t        phase_r, phase_nxt;
  logic [1:0]    byte_r, byte_nxt;
  logic [BW-1:0] left_r, left_nxt;
  logic [BW-1:0] blue_r, blue_nxt;
  logic [BW-1:0] green_r, green_nxt;
  logic [BW-1:0] red_r, red_nxt;
  logic [PW-1:0] pos_r, pos_nxt;

  logic          o_valid_r, o_valid_nxt;
  logic [BW-1:0] o_blue_r, o_green_r, o_red_r, o_alpha_r, o_rep_r;
  logic [PW-1:0] o_start_r;
  logic          o_last_r;

  logic          out_free;
  logic          img_full;
  logic [PW-1:0] remaining;
  logic          is_pix;
  logic          done;
  logic          fire;
  logic          load;
  logic          clip;
  logic [BW-1:0] repeat_cnt;
  logic [BW-1:0] left_after;
  logic [BW-1:0] alpha_w;
  logic          complete;

  // classify the head item against current state
  always_comb begin
    out_free   = !o_valid_r || out_tready;
    img_full   = (pos_r >= total);
    remaining  = total - pos_r;
    is_pix     = !head.is_cmd && !img_full && (phase_r != PH_HDR);
    done       = is_pix && byte_r[1] && (!depth_32 || byte_r[0]);
    pop        = head_valid && (out_free || !done);
    fire       = pop;
    load       = fire && done;
    clip       = ({{(PW-BW){1'b0}}, left_r} > remaining);
    if (phase_r == PH_RUN) begin
      repeat_cnt = clip ? remaining[BW-1:0] : left_r;
      left_after = '0;
    end else begin
      repeat_cnt = 8'd1;
      left_after = left_r - 8'd1;
    end
    alpha_w    = (depth_32 && (byte_r == 2'd3)) ? head.data : tgarle_pkg::ALPHA_OPAQUE;
    complete   = (remaining == {{(PW-BW){1'b0}}, repeat_cnt});
  end

  // next packet and pixel state
  always_comb begin
    phase_nxt = phase_r;
    byte_nxt  = byte_r;
    left_nxt  = left_r;
    blue_nxt  = blue_r;
    green_nxt = green_r;
    red_nxt   = red_r;
    pos_nxt   = pos_r;
    if (fire) begin
      priority if (head.is_cmd) begin
        phase_nxt = PH_HDR;
        byte_nxt  = 2'd0;
        left_nxt  = '0;
        pos_nxt   = '0;
      end else if (img_full) begin
        // drop bytes past the end of the image
      end else if (phase_r == PH_HDR) begin
        phase_nxt = head.is_run ? PH_RUN : PH_RAW;
        left_nxt  = head.count;
        byte_nxt  = 2'd0;
      end else begin
        unique case (byte_r)
          2'd0: begin
            blue_nxt = head.data;
            byte_nxt = 2'd1;
          end
          2'd1: begin
            green_nxt = head.data;
            byte_nxt  = 2'd2;
          end
          2'd2: begin
            red_nxt  = head.data;
            byte_nxt = depth_32 ? 2'd3 : 2'd0;
          end
          default: begin
            // alpha in 32-bit mode, late red after a depth change
            if (!depth_32) begin
              red_nxt = head.data;
            end
            byte_nxt = 2'd0;
          end
        endcase
        if (done) begin
          left_nxt = left_after;
          pos_nxt  = pos_r + {{(PW-BW){1'b0}}, repeat_cnt};
          if (left_after == '0) begin
            phase_nxt = PH_HDR;
          end
        end
      end
    end
  end

  // hold or drain the output register
  always_comb begin
    o_valid_nxt = o_valid_r;
    if (load) begin
      o_valid_nxt = 1'b1;
    end else if (out_tready) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR;
      byte_r    <= 2'd0;
      left_r    <= '0;
      blue_r    <= '0;
      green_r   <= '0;
      red_r     <= '0;
      pos_r     <= '0;
      o_valid_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      byte_r    <= byte_nxt;
      left_r    <= left_nxt;
      blue_r    <= blue_nxt;
      green_r   <= green_nxt;
      red_r     <= red_nxt;
      pos_r     <= pos_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  // capture result payload
  always_ff @(posedge clk) begin
    if (load) begin
      o_blue_r  <= blue_nxt;
      o_green_r <= green_nxt;
      o_red_r   <= red_nxt;
      o_alpha_r <= alpha_w;
      o_start_r <= pos_r;
      o_rep_r   <= repeat_cnt;
      o_last_r  <= complete;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = {o_rep_r, o_start_r, o_alpha_r, o_red_r, o_green_r, o_blue_r};
  assign out_tlast  = o_last_r;

endmodule

FILE: src/tga_rle_pixel_decoder_unit.sv
// Top level of the TGA run-length pixel decoder: configuration registers,
// image size product, front queue and back decoder. Depends on tgarle_pkg,
// tgarle_front, tgarle_back and tga_rle_pixel_decoder_unit_assert.svh.
//
// Usage:
//   in_*  : one compressed byte per item (in_tdata), in_tuser = 1 starts a
//           new image and clears position and packet state.
//   out_* : one item per finished pixel: BGRA, raster start index and repeat
//           count in out_tdata; out_tlast marks the pixel that fills the image.
//   cfg_* : write pixel depth, width and height while the block is idle.
// Path: the byte that completes a result is accepted, passes through the front
//   queue and then loads the output register, which drives out_tvalid.
// Throughput: one input item per cycle, set by the back state update, unless
//   a held result stalls it; the QUEUE_DEPTH-entry queue absorbs ready lag.
// Reset: clears queue, packet state and position; depth 24-bit, size 1 x 1.
// Stall: with out_tready low the result is held, the back part still consumes
//   bytes that give no result, and in_tready drops once the queue is full.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [tgarle_pkg::BYTE_W-1:0]        in_tdata,   // [7:0] data_byte
  input  logic                                 in_tuser,   // [0] action
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [7:0] blue, [15:8] green, [23:16] red, [31:24] alpha,
  // [63:32] start_index, [71:64] repeat_count
  output logic [tgarle_pkg::OUT_D_W-1:0]       out_tdata,
  output logic                                 out_tlast,  // image_complete
  input  logic                                 cfg_wr_en,
  input  logic [tgarle_pkg::CFG_A_W-1:0]       cfg_addr,
  input  logic [tgarle_pkg::DIM_W-1:0]         cfg_wdata
);

  logic                           depth_r;
  logic [tgarle_pkg::DIM_W-1:0]   width_r;
  logic [tgarle_pkg::DIM_W-1:0]   height_r;
  logic [tgarle_pkg::POS_W-1:0]   total_r;
  logic [tgarle_pkg::POS_W-1:0]   total_nxt;

  tgarle_pkg::q_item_t            head;
  logic                           head_valid;
  logic                           pop;
  tgarle_pkg::q_status_t          q_status;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= 1'b0;
      width_r  <= 16'd1;
      height_r <= 16'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        tgarle_pkg::CFG_PIXEL_DEPTH_32: depth_r  <= cfg_wdata[0];
        tgarle_pkg::CFG_IMAGE_WIDTH:    width_r  <= cfg_wdata;
        tgarle_pkg::CFG_IMAGE_HEIGHT:   height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // register the pixel count of the image
  assign total_nxt = tgarle_pkg::POS_W'(width_r) * tgarle_pkg::POS_W'(height_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= 32'd1;
    end else begin
      total_r <= total_nxt;
    end
  end

  tgarle_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .status     (q_status)
  );

  tgarle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .depth_32   (depth_r),
    .total      (total_r),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`include "tga_rle_pixel_decoder_unit_assert.svh"

  // repeat count of a result is between one and a full run of 128
  `TGA_ASSERT(a_repeat_range, clk, rst_n, out_tvalid |-> ((out_tdata[71:64] - 8'd1) < 8'd128))
  // the back part never takes from an empty queue
  `TGA_ASSERT_NEVER(a_no_pop_empty, clk, rst_n, pop && q_status.empty)
  // no item is accepted into a full queue
  `TGA_ASSERT_NEVER(a_no_push_full, clk, rst_n, in_tvalid && in_tready && q_status.full)
  // a waiting item is always taken while the output side can accept
  `TGA_ASSERT(a_no_idle_stall, clk, rst_n, (!q_status.empty && (!out_tvalid || out_tready)) |-> pop)

endmodule
